### src/dram_row_buffer_latency_macros.svh
// Assertion macros for the DRAM row buffer latency block.
// Included by the top level; depends on nothing else.
`ifndef DRAM_ROW_BUFFER_LATENCY_MACROS_SVH
`define DRAM_ROW_BUFFER_LATENCY_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DRBL_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drbl: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define DRBL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drbl: next-cycle check failed");

`endif

### src/drbl_pkg.sv
// Package for the DRAM row buffer latency block: sizes, register indexes,
// outcome codes and the item structs. Depends on nothing.
package drbl_pkg;

   localparam int BANK_COUNT         = 16;
   localparam int LINES_PER_ROW_BITS = 4;
   localparam int ADDRESS_BITS       = 32;

   localparam int LINE_ADDR_W = 32;
   localparam int ADDR_USED_W = (ADDRESS_BITS < LINE_ADDR_W) ? ADDRESS_BITS : LINE_ADDR_W;
   localparam int BANK_W      = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int ROW_LSB     = LINES_PER_ROW_BITS + BANK_W;
   localparam int ROW_W       = ADDR_USED_W - ROW_LSB;

   localparam int LAT_W   = 10;
   localparam int TIME_W  = 8;
   localparam int COUNT_W = 48;
   localparam int SUM_W   = 56;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [LAT_W-1:0]  FIXED_LATENCY_RESET = LAT_W'(100);
   localparam logic [TIME_W-1:0] T_ACTIVATE_RESET    = TIME_W'(45);
   localparam logic [TIME_W-1:0] T_COLUMN_RESET      = TIME_W'(45);
   localparam logic [TIME_W-1:0] T_PRECHARGE_RESET   = TIME_W'(45);
   localparam logic [TIME_W-1:0] T_TRANSFER_RESET    = TIME_W'(10);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_MODE      = 3'd0,
      CSR_FIXED_LATENCY = 3'd1,
      CSR_T_ACTIVATE    = 3'd2,
      CSR_T_COLUMN      = 3'd3,
      CSR_T_PRECHARGE   = 3'd4,
      CSR_T_TRANSFER    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      OUTCOME_FIXED    = 2'd0,
      OUTCOME_HIT      = 2'd1,
      OUTCOME_CONFLICT = 2'd2,
      OUTCOME_EMPTY    = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [LINE_ADDR_W-1:0] line_address;
      logic                   is_write;
   } req_type;

   typedef struct packed {
      logic [LAT_W-1:0]   latency;
      outcome_type        outcome;
      logic [COUNT_W-1:0] reads_seen;
      logic [COUNT_W-1:0] writes_seen;
      logic [SUM_W-1:0]   read_latency_sum;
      logic [SUM_W-1:0]   write_latency_sum;
   } rsp_type;

endpackage

### src/dram_row_buffer_latency.sv
// Top level of the DRAM row buffer latency block: open-page timing per bank
// and saturating access statistics. Depends on drbl_pkg and the macros header.
`include "dram_row_buffer_latency_macros.svh"

// An item (line address and read/write flag) is taken at every clock edge at
// which start is high; busy is always low, so one item can be taken in every
// cycle. Each item gives exactly one result, shown on rsp_data for one cycle
// with rsp_valid high. The item passes through the input register and then
// the result register before its result appears. The receiver cannot stall
// the block and must take the result in that cycle. The input stage registers
// the item; the lookup stage looks up the selected bank,
// forms the latency, updates the bank's open row and the statistics, and
// registers the result. Because the bank table and counters change at the
// end of the lookup stage, an access to a bank right after another access to
// the same bank sees the row that the earlier access opened. Configuration
// registers are written through the csr_ port, and should only be written
// while no item is in flight. The stored row of a bank has no reset; its
// comparison only counts once the bank's open bit is set.
module dram_row_buffer_latency (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  drbl_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output drbl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [drbl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [drbl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic                          row_mode_ff;
   logic [drbl_pkg::LAT_W-1:0]    fixed_latency_ff;
   logic [drbl_pkg::TIME_W-1:0]   t_activate_ff;
   logic [drbl_pkg::TIME_W-1:0]   t_column_ff;
   logic [drbl_pkg::TIME_W-1:0]   t_precharge_ff;
   logic [drbl_pkg::TIME_W-1:0]   t_transfer_ff;

   // Input stage.
   logic                          req_valid_ff;
   drbl_pkg::req_type             req_ff;

   // Bank table: open bits are cleared by reset, rows are not.
   logic [drbl_pkg::BANK_COUNT-1:0] bank_open_ff;
   logic [drbl_pkg::ROW_W-1:0]      bank_row_ff [drbl_pkg::BANK_COUNT];

   // Statistics.
   logic [drbl_pkg::COUNT_W-1:0]  read_count_ff;
   logic [drbl_pkg::COUNT_W-1:0]  write_count_ff;
   logic [drbl_pkg::SUM_W-1:0]    read_sum_ff;
   logic [drbl_pkg::SUM_W-1:0]    write_sum_ff;
   logic [drbl_pkg::COUNT_W-1:0]  read_count_in;
   logic [drbl_pkg::COUNT_W-1:0]  write_count_in;
   logic [drbl_pkg::SUM_W-1:0]    read_sum_in;
   logic [drbl_pkg::SUM_W-1:0]    write_sum_in;

   // Result stage.
   logic                          rsp_valid_ff;
   drbl_pkg::rsp_type             rsp_ff;

   // Lookup and latency.
   logic [drbl_pkg::ADDR_USED_W-1:0] addr_used;
   logic [drbl_pkg::BANK_W-1:0]      bank_field;
   logic [drbl_pkg::BANK_W-1:0]      bank_sel;
   logic [drbl_pkg::ROW_W-1:0]       row_sel;
   logic                             sel_open;
   logic                             sel_match;
   logic [drbl_pkg::LAT_W-1:0]       base_latency;
   logic [drbl_pkg::LAT_W-1:0]       latency;
   drbl_pkg::outcome_type            outcome;
   logic                             bank_update;

   logic                             read_cnt_carry;
   logic [drbl_pkg::COUNT_W-1:0]     read_cnt_sum;
   logic                             write_cnt_carry;
   logic [drbl_pkg::COUNT_W-1:0]     write_cnt_sum;
   logic                             read_sum_carry;
   logic [drbl_pkg::SUM_W-1:0]       read_sum_add;
   logic                             write_sum_carry;
   logic [drbl_pkg::SUM_W-1:0]       write_sum_add;

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration writes; indexes beyond the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_mode_ff      <= 1'b0;
         fixed_latency_ff <= drbl_pkg::FIXED_LATENCY_RESET;
         t_activate_ff    <= drbl_pkg::T_ACTIVATE_RESET;
         t_column_ff      <= drbl_pkg::T_COLUMN_RESET;
         t_precharge_ff   <= drbl_pkg::T_PRECHARGE_RESET;
         t_transfer_ff    <= drbl_pkg::T_TRANSFER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            drbl_pkg::CSR_ROW_MODE:      row_mode_ff      <= csr_wdata[0];
            drbl_pkg::CSR_FIXED_LATENCY: fixed_latency_ff <= csr_wdata[drbl_pkg::LAT_W-1:0];
            drbl_pkg::CSR_T_ACTIVATE:    t_activate_ff    <= csr_wdata[drbl_pkg::TIME_W-1:0];
            drbl_pkg::CSR_T_COLUMN:      t_column_ff      <= csr_wdata[drbl_pkg::TIME_W-1:0];
            drbl_pkg::CSR_T_PRECHARGE:   t_precharge_ff   <= csr_wdata[drbl_pkg::TIME_W-1:0];
            drbl_pkg::CSR_T_TRANSFER:    t_transfer_ff    <= csr_wdata[drbl_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // Bank field sits just above the line-in-row bits; the row is everything
   // above the bank field. The modulo only matters for a bank count that is
   // not a power of two.
   always_comb begin
      addr_used    = req_ff.line_address[drbl_pkg::ADDR_USED_W-1:0];
      bank_field   = addr_used[drbl_pkg::LINES_PER_ROW_BITS +: drbl_pkg::BANK_W];
      bank_sel     = drbl_pkg::BANK_W'(bank_field % drbl_pkg::BANK_COUNT);
      row_sel      = addr_used[drbl_pkg::ADDR_USED_W-1:drbl_pkg::ROW_LSB];
      sel_open     = bank_open_ff[bank_sel];
      sel_match    = (bank_row_ff[bank_sel] == row_sel);
      base_latency = drbl_pkg::LAT_W'(t_column_ff) + drbl_pkg::LAT_W'(t_transfer_ff);

      // The largest open-page latency is four 8-bit timings, which fits.
      if (!row_mode_ff) begin
         latency = fixed_latency_ff;
         outcome = drbl_pkg::OUTCOME_FIXED;
      end else if (sel_open && sel_match) begin
         latency = base_latency;
         outcome = drbl_pkg::OUTCOME_HIT;
      end else if (sel_open) begin
         latency = base_latency + drbl_pkg::LAT_W'(t_precharge_ff)
                   + drbl_pkg::LAT_W'(t_activate_ff);
         outcome = drbl_pkg::OUTCOME_CONFLICT;
      end else begin
         latency = base_latency + drbl_pkg::LAT_W'(t_activate_ff);
         outcome = drbl_pkg::OUTCOME_EMPTY;
      end

      bank_update = req_valid_ff && row_mode_ff && (outcome != drbl_pkg::OUTCOME_HIT);
   end

   // Saturating statistics: a carry out of the adder means the limit is hit.
   always_comb begin
      {read_cnt_carry, read_cnt_sum} =
         {1'b0, read_count_ff} + (drbl_pkg::COUNT_W+1)'(1);
      {write_cnt_carry, write_cnt_sum} =
         {1'b0, write_count_ff} + (drbl_pkg::COUNT_W+1)'(1);
      {read_sum_carry, read_sum_add} =
         {1'b0, read_sum_ff} + (drbl_pkg::SUM_W+1)'(latency);
      {write_sum_carry, write_sum_add} =
         {1'b0, write_sum_ff} + (drbl_pkg::SUM_W+1)'(latency);

      read_count_in  = read_count_ff;
      write_count_in = write_count_ff;
      read_sum_in    = read_sum_ff;
      write_sum_in   = write_sum_ff;
      if (req_valid_ff) begin
         if (req_ff.is_write) begin
            write_count_in = write_cnt_carry ? '1 : write_cnt_sum;
            write_sum_in   = write_sum_carry ? '1 : write_sum_add;
         end else begin
            read_count_in = read_cnt_carry ? '1 : read_cnt_sum;
            read_sum_in   = read_sum_carry ? '1 : read_sum_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_open_ff   <= '0;
         read_count_ff  <= '0;
         write_count_ff <= '0;
         read_sum_ff    <= '0;
         write_sum_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (bank_update) begin
            bank_open_ff[bank_sel] <= 1'b1;
         end
         read_count_ff  <= read_count_in;
         write_count_ff <= write_count_in;
         read_sum_ff    <= read_sum_in;
         write_sum_ff   <= write_sum_in;
         rsp_valid_ff   <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (bank_update) begin
         bank_row_ff[bank_sel] <= row_sel;
      end
   end

   // Result register carries the statistics including this access.
   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff.latency           <= latency;
         rsp_ff.outcome           <= outcome;
         rsp_ff.reads_seen        <= read_count_in;
         rsp_ff.writes_seen       <= write_count_in;
         rsp_ff.read_latency_sum  <= read_sum_in;
         rsp_ff.write_latency_sum <= write_sum_in;
      end
   end

   // Every taken item shows up as a result after the input and result registers.
   `DRBL_ASSERT_IMPLY(a_rsp_follows_req, clock, reset, start && !busy, ##2 rsp_valid)
   // Statistics only move when an item is in the lookup stage.
   `DRBL_ASSERT_NEXT(a_stats_hold_idle, clock, reset, !req_valid_ff,
                     $stable(read_count_ff) && $stable(write_sum_ff))
   // Saturating counters never go backward outside reset.
   `DRBL_ASSERT_IMPLY(a_count_monotonic, clock, reset, !$past(reset),
                      read_count_ff >= $past(read_count_ff))

endmodule

### tb/dram_row_buffer_latency_tb.sv
// Self-checking testbench for dram_row_buffer_latency: a bank-table predictor,
// a bursty command driver and a result monitor that compares every field.
// Depends on drbl_pkg and the RTL of the block; reads no files.
module dram_row_buffer_latency_tb;
   import drbl_pkg::*;

   // Run limits. The cycle limit lies well above the length of any correct run,
   // so it only trips on a hang or on results that never come.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 64;
   localparam int QUIET_CYCLES = 4;

   localparam int ROWS_PER_BANK = 3;
   localparam int PHASE_ITEMS   = 125;
   localparam int RANDOM_PHASES = 6;

   // Register indexes past the end of the register file; writes to them
   // must be dropped by the block.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
   localparam logic [63:0] SUM_MAX   = (64'd1 << SUM_W) - 64'd1;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Items waiting to be driven, and the results predicted for items that
   // the block has already taken, oldest first.
   req_type access_queue[$];
   rsp_type expected_costs[$];

   // Mirror of the configuration registers.
   logic              cfg_open_page;
   logic [LAT_W-1:0]  cfg_fixed_latency;
   logic [TIME_W-1:0] cfg_activate;
   logic [TIME_W-1:0] cfg_column;
   logic [TIME_W-1:0] cfg_precharge;
   logic [TIME_W-1:0] cfg_transfer;

   // Mirror of the bank table and of the running statistics.
   logic              open_bank_valid [BANK_COUNT];
   logic [ROW_W-1:0]  open_bank_row [BANK_COUNT];
   logic [63:0]       reads_total;
   logic [63:0]       writes_total;
   logic [63:0]       read_cycles_total;
   logic [63:0]       write_cycles_total;

   // Rows that the random part picks from, a few per bank, so that hits and
   // conflicts both come up often.
   logic [ROW_W-1:0]  row_pool [BANK_COUNT][ROWS_PER_BANK];

   int failures;
   int settings_count;
   int outcome_tally [4];
   int cycle_count;
   int burst_left;
   int gap_left;

   dram_row_buffer_latency u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Adds b to a and sticks at limit instead of wrapping.
   function automatic logic [63:0] capped_add(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] limit);
      if (a >= limit || b > limit - a) begin
         return limit;
      end
      return a + b;
   endfunction

   // Works out the result of one access and moves the bank table and the
   // statistics on, just as the block does when it takes the item.
   function automatic rsp_type predict_access_cost(input req_type item);
      rsp_type          result;
      logic [BANK_W-1:0] field;
      int unsigned      bank;
      logic [ROW_W-1:0] row;
      int unsigned      cost;
      logic [LAT_W-1:0] latency;
      result = '0;
      if (!cfg_open_page) begin
         // Fixed mode leaves the bank table alone.
         cost = cfg_fixed_latency;
         result.outcome = OUTCOME_FIXED;
      end else begin
         field = item.line_address[LINES_PER_ROW_BITS +: BANK_W];
         bank  = field % BANK_COUNT;
         row   = item.line_address[ROW_LSB +: ROW_W];
         cost  = cfg_column + cfg_transfer;
         if (open_bank_valid[bank] && open_bank_row[bank] == row) begin
            result.outcome = OUTCOME_HIT;
         end else if (open_bank_valid[bank]) begin
            cost += cfg_precharge + cfg_activate;
            open_bank_row[bank] = row;
            result.outcome = OUTCOME_CONFLICT;
         end else begin
            cost += cfg_activate;
            open_bank_row[bank]   = row;
            open_bank_valid[bank] = 1'b1;
            result.outcome = OUTCOME_EMPTY;
         end
      end
      latency = LAT_W'(cost);
      if (item.is_write) begin
         writes_total       = capped_add(writes_total, 64'd1, COUNT_MAX);
         write_cycles_total = capped_add(write_cycles_total, 64'(latency), SUM_MAX);
      end else begin
         reads_total       = capped_add(reads_total, 64'd1, COUNT_MAX);
         read_cycles_total = capped_add(read_cycles_total, 64'(latency), SUM_MAX);
      end
      result.latency           = latency;
      result.reads_seen        = reads_total[COUNT_W-1:0];
      result.writes_seen       = writes_total[COUNT_W-1:0];
      result.read_latency_sum  = read_cycles_total[SUM_W-1:0];
      result.write_latency_sum = write_cycles_total[SUM_W-1:0];
      return result;
   endfunction

   // Mostly addresses whose row comes from the pool of the chosen bank; the
   // rest are fully random. Bits below the bank field are always random.
   function automatic logic [LINE_ADDR_W-1:0] make_address();
      int unsigned            bank;
      logic [LINE_ADDR_W-1:0] address;
      address = $urandom;
      if ($urandom_range(0, 99) < 15) begin
         return address;
      end
      bank = $urandom_range(0, BANK_COUNT - 1);
      address[LINES_PER_ROW_BITS +: BANK_W] = BANK_W'(bank);
      address[ROW_LSB +: ROW_W] = row_pool[bank][$urandom_range(0, ROWS_PER_BANK - 1)];
      return address;
   endfunction

   task automatic queue_access(input logic [LINE_ADDR_W-1:0] address, input logic is_write);
      req_type item;
      item.line_address = address;
      item.is_write     = is_write;
      access_queue.push_back(item);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Waits until every queued item has been taken and every result has come
   // back, then waits out the quiet period. Results that never arrive are
   // reported here and dropped so the next phase starts clean.
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      while (access_queue.size() != 0 || start) begin
         @(negedge clock);
      end
      while (expected_costs.size() != 0 && waited < DRAIN_CYCLES) begin
         @(negedge clock);
         waited++;
      end
      if (expected_costs.size() != 0) begin
         $error("%0d expected results never arrived", expected_costs.size());
         failures++;
         expected_costs.delete();
      end
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // One register write. The mirror follows at the edge that does the write,
   // when no item is in flight.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_ROW_MODE:      cfg_open_page     = value[0];
         CSR_FIXED_LATENCY: cfg_fixed_latency = value[LAT_W-1:0];
         CSR_T_ACTIVATE:    cfg_activate      = value[TIME_W-1:0];
         CSR_T_COLUMN:      cfg_column        = value[TIME_W-1:0];
         CSR_T_PRECHARGE:   cfg_precharge     = value[TIME_W-1:0];
         CSR_T_TRANSFER:    cfg_transfer      = value[TIME_W-1:0];
         default: ;
      endcase
   endtask

   // Rewrites every register once the block is idle. The unused upper data
   // bits carry random junk, which the block has to mask off.
   task automatic apply_settings(input logic mode, input logic [LAT_W-1:0] fixed,
                                 input logic [TIME_W-1:0] activate,
                                 input logic [TIME_W-1:0] column,
                                 input logic [TIME_W-1:0] precharge,
                                 input logic [TIME_W-1:0] transfer);
      settle();
      write_register(CSR_ROW_MODE, {9'($urandom), mode});
      write_register(CSR_FIXED_LATENCY, fixed);
      write_register(CSR_T_ACTIVATE, {2'($urandom), activate});
      write_register(CSR_T_COLUMN, {2'($urandom), column});
      write_register(CSR_T_PRECHARGE, {2'($urandom), precharge});
      write_register(CSR_T_TRANSFER, {2'($urandom), transfer});
      settings_count++;
   endtask

   // Driver. An item is taken at an edge where start is high and busy is
   // low; the prediction is made at that same edge from the item that was on
   // the bus. The sender works in bursts of random length with random gaps,
   // and about a third of the bursts follow the previous one with no gap at
   // all, so long back-to-back stretches occur too. During a gap the request
   // bus carries noise that the block must ignore.
   always @(posedge clock) begin : driver
      req_type next_item;
      logic    next_start;
      next_item  = req_data;
      next_start = start;
      if (reset) begin
         next_start = 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (start && !busy) begin
            expected_costs.push_back(predict_access_cost(req_data));
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               next_start             = 1'b0;
               next_item.line_address = $urandom;
               next_item.is_write     = 1'($urandom);
            end else if (access_queue.size() != 0) begin
               next_item  = access_queue.pop_front();
               next_start = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               next_start = 1'b0;
            end
         end
      end
      start    <= next_start;
      req_data <= next_item;
   end

   // Monitor. A result is shown for exactly one cycle and is taken at the
   // edge that ends it; outputs are sampled before that edge's updates.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_costs.size() == 0) begin
            $error("result with latency %0d arrived with no access pending",
                   rsp_data.latency);
            failures++;
         end else begin
            want = expected_costs.pop_front();
            check_field("latency", 64'(want.latency), 64'(rsp_data.latency));
            check_field("outcome", 64'(want.outcome), 64'(rsp_data.outcome));
            check_field("reads_seen", 64'(want.reads_seen), 64'(rsp_data.reads_seen));
            check_field("writes_seen", 64'(want.writes_seen), 64'(rsp_data.writes_seen));
            check_field("read_latency_sum", 64'(want.read_latency_sum),
                        64'(rsp_data.read_latency_sum));
            check_field("write_latency_sum", 64'(want.write_latency_sum),
                        64'(rsp_data.write_latency_sum));
            outcome_tally[want.outcome]++;
         end
      end
   end

   // Watchdog: ends a run that hangs or loses results.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      int b;
      int r;
      logic mode;

      // Every input has a known value from time zero, and the mirrors start
      // at the register reset values with all banks closed.
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      failures       = 0;
      settings_count = 0;
      cycle_count    = 0;
      for (b = 0; b < 4; b++) begin
         outcome_tally[b] = 0;
      end
      cfg_open_page     = 1'b0;
      cfg_fixed_latency = FIXED_LATENCY_RESET;
      cfg_activate      = T_ACTIVATE_RESET;
      cfg_column        = T_COLUMN_RESET;
      cfg_precharge     = T_PRECHARGE_RESET;
      cfg_transfer      = T_TRANSFER_RESET;
      for (b = 0; b < BANK_COUNT; b++) begin
         open_bank_valid[b] = 1'b0;
         open_bank_row[b]   = '0;
      end
      reads_total        = '0;
      writes_total       = '0;
      read_cycles_total  = '0;
      write_cycles_total = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First fixed mode with the reset values, then the
      // extremes of the fixed latency, and writes to the spare indexes,
      // which must not change anything.
      queue_access(32'h0000_0000, 1'b0);
      queue_access(32'hFFFF_FFFF, 1'b1);
      apply_settings(1'b0, 10'd1023, 8'd45, 8'd45, 8'd45, 8'd10);
      queue_access(32'h1234_5678, 1'b0);
      apply_settings(1'b0, 10'd0, 8'd45, 8'd45, 8'd45, 8'd10);
      queue_access(32'h8765_4321, 1'b1);
      settle();
      write_register(CSR_SPARE_LOW, '1);
      write_register(CSR_SPARE_HIGH, '1);
      queue_access(32'h0F0F_0F0F, 1'b0);

      // Open-page mode with the default timings: an empty bank, a hit that
      // differs only in the line bits, a conflict to the top row, the top
      // bank, and accesses to one bank that follow each other.
      apply_settings(1'b1, 10'd100, 8'd45, 8'd45, 8'd45, 8'd10);
      queue_access(32'h0000_0000, 1'b0);
      queue_access(32'h0000_000F, 1'b1);
      queue_access(32'hFFFF_FF0F, 1'b0);
      queue_access(32'hFFFF_FFFF, 1'b1);
      queue_access(32'hFFFF_FFF0, 1'b0);
      queue_access(32'h0000_0100, 1'b0);
      queue_access(32'h0000_0200, 1'b1);
      queue_access(32'h0000_0200, 1'b0);

      // A fixed-mode access in between must leave bank 0 on row 2.
      apply_settings(1'b0, 10'd7, 8'd45, 8'd45, 8'd45, 8'd10);
      queue_access(32'h0000_0300, 1'b1);
      apply_settings(1'b1, 10'd7, 8'd45, 8'd45, 8'd45, 8'd10);
      queue_access(32'h0000_0205, 1'b0);

      // Largest latency (a conflict with every timing at its maximum), then
      // every timing at zero.
      apply_settings(1'b1, 10'd100, 8'd255, 8'd255, 8'd255, 8'd255);
      queue_access(32'h0000_0100, 1'b1);
      queue_access(32'h0000_0100, 1'b0);
      apply_settings(1'b1, 10'd100, 8'd0, 8'd0, 8'd0, 8'd0);
      queue_access(32'h0000_0300, 1'b0);
      queue_access(32'h0000_0300, 1'b1);

      // Random part. Each phase picks a register setting, refreshes the row
      // pool and sends a batch of accesses. The first two phases pin the
      // timings to their extremes and the third runs in fixed mode.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = (phase == 2) ? 1'b0 : 1'b1;
         case (phase)
            0: apply_settings(mode, 10'($urandom), 8'd255, 8'd255, 8'd255, 8'd255);
            1: apply_settings(mode, 10'($urandom), 8'd0, 8'd0, 8'd0, 8'd0);
            default: apply_settings(mode, 10'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom), 8'($urandom));
         endcase
         for (b = 0; b < BANK_COUNT; b++) begin
            for (r = 0; r < ROWS_PER_BANK; r++) begin
               row_pool[b][r] = ROW_W'($urandom);
            end
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            queue_access(make_address(), 1'($urandom));
         end
      end

      settle();
      $display("Ran %0d reads and %0d writes under %0d register settings.",
               reads_total, writes_total, settings_count);
      $display("Outcomes seen: %0d fixed, %0d row hits, %0d row conflicts, %0d empty banks.",
               outcome_tally[OUTCOME_FIXED], outcome_tally[OUTCOME_HIT],
               outcome_tally[OUTCOME_CONFLICT], outcome_tally[OUTCOME_EMPTY]);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
